>>> hw/rtl/u2cp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2cp_pkg: shared types and constants for the UTF-8 to code page transcoder
// Holds the CP437 reverse lookup and the result item type.
// ----------------------------------------------------------------------------
package u2cp_pkg;

    localparam logic [7:0] QMARK_CODE = 8'd63;
    localparam logic [0:0] PAGE_CP437 = 1'b0;
    localparam logic [0:0] PAGE_ASCII = 1'b1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_out;
        logic [2:0] char_length;
        logic       bad_sequence;
    } out_item_t;

    // Match a code point against the CP437 table; miss gives '?'
    function automatic logic [7:0] cp437_lookup(input logic [15:0] cp);
        logic [7:0] r;
        r = QMARK_CODE;
        unique case (cp)
            16'h00A0: r = 8'd255; 16'h00A1: r = 8'd173; 16'h00A2: r = 8'd155;
            16'h00A3: r = 8'd156; 16'h00A5: r = 8'd157; 16'h00A7: r = 8'd21;
            16'h00AA: r = 8'd166; 16'h00AB: r = 8'd174; 16'h00AC: r = 8'd170;
            16'h00B0: r = 8'd248; 16'h00B1: r = 8'd241; 16'h00B2: r = 8'd253;
            16'h00B5: r = 8'd230; 16'h00B6: r = 8'd20;  16'h00B7: r = 8'd250;
            16'h00BA: r = 8'd167; 16'h00BB: r = 8'd175; 16'h00BC: r = 8'd172;
            16'h00BD: r = 8'd171; 16'h00BF: r = 8'd168; 16'h00C4: r = 8'd142;
            16'h00C5: r = 8'd143; 16'h00C6: r = 8'd146; 16'h00C7: r = 8'd128;
            16'h00C9: r = 8'd144; 16'h00D1: r = 8'd165; 16'h00D6: r = 8'd153;
            16'h00DC: r = 8'd154; 16'h00DF: r = 8'd225; 16'h00E0: r = 8'd133;
            16'h00E1: r = 8'd160; 16'h00E2: r = 8'd131; 16'h00E4: r = 8'd132;
            16'h00E5: r = 8'd134; 16'h00E6: r = 8'd145; 16'h00E7: r = 8'd135;
            16'h00E8: r = 8'd138; 16'h00E9: r = 8'd130; 16'h00EA: r = 8'd136;
            16'h00EB: r = 8'd137; 16'h00EC: r = 8'd141; 16'h00ED: r = 8'd161;
            16'h00EE: r = 8'd140; 16'h00EF: r = 8'd139; 16'h00F1: r = 8'd164;
            16'h00F2: r = 8'd149; 16'h00F3: r = 8'd162; 16'h00F4: r = 8'd147;
            16'h00F6: r = 8'd148; 16'h00F7: r = 8'd246; 16'h00F9: r = 8'd151;
            16'h00FA: r = 8'd163; 16'h00FB: r = 8'd150; 16'h00FC: r = 8'd129;
            16'h00FF: r = 8'd152; 16'h0192: r = 8'd159; 16'h0393: r = 8'd226;
            16'h0398: r = 8'd233; 16'h03A3: r = 8'd228; 16'h03A6: r = 8'd232;
            16'h03A9: r = 8'd234; 16'h03B1: r = 8'd224; 16'h03B4: r = 8'd235;
            16'h03B5: r = 8'd238; 16'h03C0: r = 8'd227; 16'h03C3: r = 8'd229;
            16'h03C4: r = 8'd231; 16'h03C6: r = 8'd237; 16'h2022: r = 8'd7;
            16'h203C: r = 8'd19;  16'h207F: r = 8'd252; 16'h20A7: r = 8'd158;
            16'h2190: r = 8'd27;  16'h2191: r = 8'd24;  16'h2192: r = 8'd26;
            16'h2193: r = 8'd25;  16'h2194: r = 8'd29;  16'h2195: r = 8'd18;
            16'h21A8: r = 8'd23;  16'h2219: r = 8'd249; 16'h221A: r = 8'd251;
            16'h221E: r = 8'd236; 16'h221F: r = 8'd28;  16'h2229: r = 8'd239;
            16'h2248: r = 8'd247; 16'h2261: r = 8'd240; 16'h2264: r = 8'd243;
            16'h2265: r = 8'd242; 16'h2302: r = 8'd127; 16'h2310: r = 8'd169;
            16'h2320: r = 8'd244; 16'h2321: r = 8'd245; 16'h2500: r = 8'd196;
            16'h2502: r = 8'd179; 16'h250C: r = 8'd218; 16'h2510: r = 8'd191;
            16'h2514: r = 8'd192; 16'h2518: r = 8'd217; 16'h251C: r = 8'd195;
            16'h2524: r = 8'd180; 16'h252C: r = 8'd194; 16'h2534: r = 8'd193;
            16'h253C: r = 8'd197; 16'h2550: r = 8'd205; 16'h2551: r = 8'd186;
            16'h2552: r = 8'd213; 16'h2553: r = 8'd214; 16'h2554: r = 8'd201;
            16'h2555: r = 8'd184; 16'h2556: r = 8'd183; 16'h2557: r = 8'd187;
            16'h2558: r = 8'd212; 16'h2559: r = 8'd211; 16'h255A: r = 8'd200;
            16'h255B: r = 8'd190; 16'h255C: r = 8'd189; 16'h255D: r = 8'd188;
            16'h255E: r = 8'd198; 16'h255F: r = 8'd199; 16'h2560: r = 8'd204;
            16'h2561: r = 8'd181; 16'h2562: r = 8'd182; 16'h2563: r = 8'd185;
            16'h2564: r = 8'd209; 16'h2565: r = 8'd210; 16'h2566: r = 8'd203;
            16'h2567: r = 8'd207; 16'h2568: r = 8'd208; 16'h2569: r = 8'd202;
            16'h256A: r = 8'd216; 16'h256B: r = 8'd215; 16'h256C: r = 8'd206;
            16'h2580: r = 8'd223; 16'h2584: r = 8'd220; 16'h2588: r = 8'd219;
            16'h258C: r = 8'd221; 16'h2590: r = 8'd222; 16'h2591: r = 8'd176;
            16'h2592: r = 8'd177; 16'h2593: r = 8'd178; 16'h25A0: r = 8'd254;
            16'h25AC: r = 8'd22;  16'h25B2: r = 8'd30;  16'h25BA: r = 8'd16;
            16'h25BC: r = 8'd31;  16'h25C4: r = 8'd17;  16'h25CB: r = 8'd9;
            16'h25D8: r = 8'd8;   16'h25D9: r = 8'd10;  16'h263A: r = 8'd1;
            16'h263B: r = 8'd2;   16'h263C: r = 8'd15;  16'h2640: r = 8'd12;
            16'h2642: r = 8'd11;  16'h2660: r = 8'd6;   16'h2663: r = 8'd5;
            16'h2665: r = 8'd3;   16'h2666: r = 8'd4;   16'h266A: r = 8'd13;
            16'h266B: r = 8'd14;
            default:  r = QMARK_CODE;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/u2cp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2cp_stream_if: valid/ready channel
// Carries one request of a given payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface u2cp_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/utf8_to_codepage_transcoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_codepage_transcoder_top: UTF-8 byte stream to CP437 / ASCII codes
// Decodes one byte per cycle unless stalled; one code per finished character.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   sink of bytes (byte_in, end_of_text), valid/ready handshake.
//   out_ch  source of results (code_out, char_length, bad_sequence).
//   target_page_we/target_page_wdata write the page select (0 CP437,
//   1 ASCII); write only while the block is idle.
// Throughput is one byte per cycle while the output is not stalled. The
// decode, table match and page selection sit in one combinational pass
// between the sequence state and a single output register, so a result
// appears in the cycle after the byte that completes it. Lead and middle
// bytes of a valid sequence give no result. Malformed or truncated
// sequences give code 0, bad_sequence 1. in_ch.ready is high whenever the
// output register is empty or being taken this cycle; a stalled receiver
// holds the result and back-pressures the input until it is taken. Reset
// clears the sequence state and the output valid flag and selects CP437.
// ----------------------------------------------------------------------------
module utf8_to_codepage_transcoder_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          target_page_we,
    input  logic          target_page_wdata,
    u2cp_stream_if.sink   in_ch,
    u2cp_stream_if.source out_ch
);
    import u2cp_pkg::*;

    logic        page_reg;
    logic [20:0] cp_reg,   cp_next;
    logic [1:0]  rem_reg,  rem_next;
    logic [2:0]  taken_reg, taken_next;
    logic [7:0]  lead_reg, lead_next;
    logic        ov_reg;
    out_item_t   out_reg;

    logic        accept;
    logic        emit;
    logic        bad;
    logic [2:0]  len;
    logic [20:0] done_cp;
    logic [7:0]  conv_code;
    logic [7:0]  b;
    logic        eot;
    logic [7:0]  lo, hi;

    assign b      = in_ch.payload.byte_in;
    assign eot    = in_ch.payload.end_of_text;
    assign in_ch.ready = !ov_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;

    // Continuation bounds for the second byte of special leads
    always_comb
    begin
        lo = 8'h80;
        hi = 8'hBF;
        if (taken_reg == 3'd1)
        begin
            unique case (lead_reg)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
    end

    // Decode one byte against the pending sequence
    always_comb
    begin
        cp_next    = cp_reg;
        rem_next   = rem_reg;
        taken_next = taken_reg;
        lead_next  = lead_reg;
        emit       = 1'b0;
        bad        = 1'b0;
        len        = 3'd1;
        done_cp    = {13'd0, b};
        if (rem_reg == 2'd0)
        begin
            if (b < 8'h80)
                emit = 1'b1;
            else if (b < 8'hC2 || b > 8'hF4)
            begin
                emit = 1'b1;
                bad  = 1'b1;
            end
            else if (eot)
            begin
                emit = 1'b1;
                bad  = 1'b1;
            end
            else
            begin
                lead_next  = b;
                taken_next = 3'd1;
                if (b < 8'hE0)
                begin
                    rem_next = 2'd1;
                    cp_next  = {16'd0, b[4:0]};
                end
                else if (b < 8'hF0)
                begin
                    rem_next = 2'd2;
                    cp_next  = {17'd0, b[3:0]};
                end
                else
                begin
                    rem_next = 2'd3;
                    cp_next  = {18'd0, b[2:0]};
                end
            end
        end
        else
        begin
            len     = taken_reg + 3'd1;
            done_cp = {cp_reg[14:0], b[5:0]};
            if (b < lo || b > hi || rem_reg == 2'd1 || eot)
            begin
                emit       = 1'b1;
                bad        = (b < lo || b > hi || rem_reg != 2'd1);
                cp_next    = 21'd0;
                rem_next   = 2'd0;
                taken_next = 3'd0;
                lead_next  = 8'd0;
            end
            else
            begin
                cp_next    = done_cp;
                rem_next   = rem_reg - 2'd1;
                taken_next = len;
            end
        end
    end

    u2cp_convert u_convert
    (
        .code_point  (done_cp),
        .multi_byte  (len != 3'd1),
        .target_page (page_reg),
        .code        (conv_code)
    );

    // Hold page select and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= PAGE_CP437;
            cp_reg    <= '0;
            rem_reg   <= '0;
            taken_reg <= '0;
            lead_reg  <= '0;
        end
        else
        begin
            if (target_page_we)
                page_reg <= target_page_wdata;
            if (accept)
            begin
                cp_reg    <= cp_next;
                rem_reg   <= rem_next;
                taken_reg <= taken_next;
                lead_reg  <= lead_next;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (accept && emit)
            ov_reg <= 1'b1;
        else if (out_ch.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg.code_out     <= bad ? 8'd0 : conv_code;
            out_reg.char_length  <= len;
            out_reg.bad_sequence <= bad;
        end
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = out_reg;

    // Checks
    a_rem_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd0) == (taken_reg == 3'd0))
        else $error("remaining and taken counts disagree");
    a_len_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 2'd0 |-> ({1'b0, rem_reg} + taken_reg) <= 3'd4)
        else $error("sequence longer than four bytes");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.bad_sequence |-> out_ch.payload.code_out == 8'd0)
        else $error("error result with non-zero code");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_reg))
        else $error("stalled result changed");
endmodule

>>> hw/rtl/u2cp_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2cp_convert: code point to single-byte code
// Maps a finished code point to CP437 or ASCII with question mark.
// ----------------------------------------------------------------------------
module u2cp_convert
(
    input  logic [20:0] code_point,
    input  logic        multi_byte,
    input  logic        target_page,
    output logic [7:0]  code
);
    import u2cp_pkg::*;

    // Select the page; below 0x7F passes straight through in CP437
    always_comb
    begin
        if (target_page == PAGE_ASCII)
            code = multi_byte ? QMARK_CODE : code_point[7:0];
        else if (code_point < 21'h7F)
            code = code_point[7:0];
        else if (code_point[20:16] != 5'd0)
            code = QMARK_CODE;
        else
            code = cp437_lookup(code_point[15:0]);
    end
endmodule
